### src/gal_pkg.sv
// Shared constants and types for the gcd / lcm block.
`timescale 1ns / 1ps

package gal_pkg;

  // Default operand width.
  localparam int OPERAND_BITS_DEF = 31;

  // Operation select for the shared adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

### src/gal_if.sv
// Valid/ready channel interfaces for operands and results.
`timescale 1ns / 1ps

interface gal_in_if #(
  parameter int OPERAND_BITS = 31
);
  logic                    valid;
  logic                    ready;
  logic [OPERAND_BITS-1:0] first_operand;
  logic [OPERAND_BITS-1:0] second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

interface gal_out_if #(
  parameter int OPERAND_BITS = 31
);
  logic                      valid;
  logic                      ready;
  logic [OPERAND_BITS-1:0]   divisor_result;
  logic [2*OPERAND_BITS-1:0] multiple_result;
  logic                      both_zero;

  modport source (output valid, output divisor_result, output multiple_result,
                  output both_zero, input ready);
  modport sink   (input valid, input divisor_result, input multiple_result,
                  input both_zero, output ready);
endinterface

### src/gal_alu.sv
// Shared add/subtract unit used by the gcd subtract, divide and multiply steps.
`timescale 1ns / 1ps

module gal_alu
  import gal_pkg::*;
#(
  parameter int WIDTH = OPERAND_BITS_DEF + 2
) (
  input  alu_op_t          op,
  input  logic [WIDTH-1:0] opa,
  input  logic [WIDTH-1:0] opb,
  output logic [WIDTH-1:0] res
);

  always_comb begin
    case (op)
      ALU_ADD: res = opa + opb;
      ALU_SUB: res = opa - opb;
      default: res = opa + opb;
    endcase
  end

endmodule

### src/gal_core.sv
// Sequencer and datapath: binary gcd, restoring divide, shift-add multiply.
`timescale 1ns / 1ps

module gal_core
  import gal_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [OPERAND_BITS-1:0]   a_in,
  input  logic [OPERAND_BITS-1:0]   b_in,
  output logic                      idle,
  output logic                      done,
  input  logic                      take,
  output logic [OPERAND_BITS-1:0]   gcd_out,
  output logic [2*OPERAND_BITS-1:0] lcm_out,
  output logic                      zero_out
);

  localparam int W  = OPERAND_BITS;
  localparam int AW = W + 2;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_STRIP = 9'b000000010,
    S_XODD  = 9'b000000100,
    S_YODD  = 9'b000001000,
    S_SUB   = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  g_r, g_nxt;
  logic [W-1:0]  hi_r, hi_nxt;   // remainder during divide, product high half during multiply
  logic [W-1:0]  n_r, n_nxt;     // dividend/quotient, then product low half
  logic [CW-1:0] shift_r, shift_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          zero_r, zero_nxt;

  alu_op_t       alu_op;
  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic          borrow;

  gal_alu #(.WIDTH(AW)) u_alu (
    .op  (alu_op),
    .opa (alu_a),
    .opb (alu_b),
    .res (alu_res)
  );

  assign borrow = alu_res[AW-1];

  // Operand select for the shared adder.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      S_SUB: begin
        alu_op = ALU_SUB;
        alu_a  = {2'b00, y_r};
        alu_b  = {2'b00, x_r};
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, hi_r, n_r[W-1]};
        alu_b  = {2'b00, g_r};
      end
      S_MUL: begin
        alu_op = ALU_ADD;
        alu_a  = {2'b00, hi_r};
        alu_b  = n_r[0] ? {2'b00, b_r} : '0;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    g_nxt     = g_r;
    hi_nxt    = hi_r;
    n_nxt     = n_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt     = a_in;
          b_nxt     = b_in;
          x_nxt     = a_in;
          y_nxt     = b_in;
          shift_nxt = '0;
          zero_nxt  = (a_in == '0) && (b_in == '0);
          if ((a_in == '0) || (b_in == '0)) begin
            g_nxt     = a_in | b_in;
            hi_nxt    = '0;
            n_nxt     = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_STRIP;
          end
        end
      end
      S_STRIP: begin
        if (x_r[0] || y_r[0]) begin
          state_nxt = S_XODD;
        end else begin
          x_nxt     = x_r >> 1;
          y_nxt     = y_r >> 1;
          shift_nxt = shift_r + 1'b1;
        end
      end
      S_XODD: begin
        if (x_r[0]) begin
          state_nxt = S_YODD;
        end else begin
          x_nxt = x_r >> 1;
        end
      end
      S_YODD: begin
        if (y_r == '0) begin
          state_nxt = S_GCD;
        end else if (y_r[0]) begin
          state_nxt = S_SUB;
        end else begin
          y_nxt = y_r >> 1;
        end
      end
      S_SUB: begin
        // y < x: swap this cycle, subtract on the next
        if (borrow) begin
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          y_nxt     = alu_res[W-1:0];
          state_nxt = S_YODD;
        end
      end
      S_GCD: begin
        g_nxt     = x_r << shift_r;
        n_nxt     = a_r;
        hi_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!borrow) begin
          hi_nxt = alu_res[W-1:0];
        end else begin
          hi_nxt = {hi_r[W-2:0], n_r[W-1]};
        end
        n_nxt   = {n_r[W-2:0], ~borrow};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          // g divides a, so the remainder is zero; hi starts the product
          hi_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        hi_nxt  = alu_res[W:1];
        n_nxt   = {alu_res[0], n_r[W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    g_r     <= g_nxt;
    hi_r    <= hi_nxt;
    n_r     <= n_nxt;
    shift_r <= shift_nxt;
    cnt_r   <= cnt_nxt;
    zero_r  <= zero_nxt;
  end

  assign idle     = (state_r == S_IDLE);
  assign done     = (state_r == S_DONE);
  assign gcd_out  = g_r;
  assign lcm_out  = {hi_r, n_r};
  assign zero_out = zero_r;

endmodule

### src/gcd_and_lcm_top.sv
// Top level: gcd and exact lcm of two unsigned operands.
`timescale 1ns / 1ps

// Takes two unsigned OPERAND_BITS-bit operands per transaction and returns their gcd, their
// exact 2*OPERAND_BITS-bit lcm and a flag set when both operands are zero (gcd and lcm 0);
// with one operand zero the gcd is the other operand and the lcm is 0. One item is processed
// at a time through a single shared add/subtract unit: a binary gcd loop (shifts, swaps and
// subtracts, data dependent), then a restoring divide of the first operand by the gcd and a
// shift-add multiply by the second operand; a pair with a zero operand skips these steps. A
// result register on the output lets the next operand pair be taken while a result waits.
module gcd_and_lcm_top
  import gal_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gal_in_if.sink     in_ch,
  gal_out_if.source  out_ch
);

  logic                      core_idle;
  logic                      core_done;
  logic                      core_take;
  logic [OPERAND_BITS-1:0]   core_gcd;
  logic [2*OPERAND_BITS-1:0] core_lcm;
  logic                      core_zero;

  logic                      out_valid_r, out_valid_nxt;
  logic [OPERAND_BITS-1:0]   gcd_r;
  logic [2*OPERAND_BITS-1:0] lcm_r;
  logic                      zero_r;

  gal_core #(.OPERAND_BITS(OPERAND_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_ch.valid && core_idle),
    .a_in     (in_ch.first_operand),
    .b_in     (in_ch.second_operand),
    .idle     (core_idle),
    .done     (core_done),
    .take     (core_take),
    .gcd_out  (core_gcd),
    .lcm_out  (core_lcm),
    .zero_out (core_zero)
  );

  assign in_ch.ready = core_idle;

  // Move a finished result into the output register once it is free or draining.
  assign core_take = core_done && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (core_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (core_take) begin
      gcd_r  <= core_gcd;
      lcm_r  <= core_lcm;
      zero_r <= core_zero;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.divisor_result  = gcd_r;
  assign out_ch.multiple_result = lcm_r;
  assign out_ch.both_zero       = zero_r;

endmodule
